// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for clocked concurrent assertions on clk_i / rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge of clk_i outside reset.
`define EIL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition must never be true at a rising edge of clk_i outside reset.
`define EIL_ASSERT_NEVER(name, cond, msg) \
  `EIL_ASSERT(name, !(cond), msg)

`endif

// ----- sv/eil_pkg.sv -----
// ----------------------------------------------------------------------------
// eil_pkg
// Codes, state encoding and controller/datapath interface types for the
// eta interpolation lookup block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eil_pkg;

  localparam logic [1:0] CMD_WR_CENTER = 2'd0;
  localparam logic [1:0] CMD_WR_VALUE  = 2'd1;
  localparam logic [1:0] CMD_QUERY     = 2'd2;

  localparam logic [1:0] REGION_INTERP = 2'd0;
  localparam logic [1:0] REGION_BELOW  = 2'd1;
  localparam logic [1:0] REGION_ABOVE  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_LO,
    ST_CHK_HI,
    ST_PROBE_RD,
    ST_PROBE_CMP,
    ST_RD_RIGHT,
    ST_LATCH_R,
    ST_PREP,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } eil_state_e;

  typedef enum logic [2:0] {
    RA_ZERO,
    RA_LAST,
    RA_MID,
    RA_LEFT,
    RA_RIGHT
  } eil_raddr_e;

  typedef enum logic [1:0] {
    RS_READ,
    RS_LEFT,
    RS_INTERP
  } eil_res_e;

  typedef struct packed {
    logic       wr_center;
    logic       wr_value;
    logic       x_load;
    eil_raddr_e rd_sel;
    logic       search_init;
    logic       probe_issue;
    logic       probe_update;
    logic       left_latch;
    logic       right_latch;
    logic       prep;
    logic       mul_load;
    logic       div_start;
    logic       res_load;
    eil_res_e   res_sel;
    logic [1:0] res_region;
    logic       out_load;
  } eil_ctl_t;

  typedef struct packed {
    logic x_le_c;
    logic x_ge_c;
    logic cnt_zero;
    logic den_le0;
    logic div_done;
    logic out_free;
  } eil_sts_t;

endpackage

// ----- sv/eta_interpolation_lookup_core.sv -----
// ----------------------------------------------------------------------------
// eta_interpolation_lookup_core
// Piecewise linear lookup over a table of ascending bin centers (signed
// Q16.16) and matching eta values. Write beats each store a center or a
// value and are taken back to back. A query beat returns one result: the
// first or last value when the position is at or beyond the table ends,
// otherwise the value interpolated on the segment that ends at the first
// center not below the position, truncated toward the left value. An
// interpolated query runs a binary search of at most log2(bin count) + 1
// probes, each a memory read and a compare, then a multiply and a
// bit-serial divide. One query is in work at a time, while a finished
// result may still sit in the output register. Tables are not cleared by
// reset and must be written before they are queried.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eta_interpolation_lookup_core #(
  parameter int unsigned MAX_BINS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_en_i,
  input  logic [8:0]         cfg_wr_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         bin_index_i,
  input  logic signed [31:0] operand_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] eta_result_o,
  output logic [1:0]         region_o
);

  import eil_pkg::*;

  eil_ctl_t ctl;
  eil_sts_t sts;

  eil_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  eil_dpath #(
    .MAX_BINS (MAX_BINS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .bin_index_i     (bin_index_i),
    .operand_value_i (operand_value_i),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .eta_result_o    (eta_result_o),
    .region_o        (region_o)
  );

  // A query beat always occupies the block for at least the next cycle.
  `EIL_ASSERT(a_query_blocks, (in_valid_i && !in_stall_o && (cmd_i == CMD_QUERY)) |=> in_stall_o, "query accepted without going busy")

  // Write and unknown beats never leave the block busy.
  `EIL_ASSERT(a_write_no_busy, (in_valid_i && !in_stall_o && (cmd_i != CMD_QUERY)) |=> !in_stall_o, "non-query beat made the block busy")

  // The output register is only loaded when its beat has gone or is leaving.
  `EIL_ASSERT_NEVER(a_no_overwrite, ctl.out_load && !sts.out_free, "result overwrote a pending beat")

  // Every new output beat comes from a controller hand-off.
  `EIL_ASSERT(a_out_from_load, $rose(out_valid_o) |-> $past(ctl.out_load), "output valid rose without a load")

endmodule

// ----- sv/eil_div.sv -----
// ----------------------------------------------------------------------------
// eil_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit
// divisor. The caller guarantees the quotient fits in 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eil_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic [31:0] quotient_o,
  output logic        done_o
);

  localparam int unsigned Steps = 32;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [31:0]     rem_q, rem_d;
  logic [31:0]     quo_q, quo_d;
  logic [31:0]     dsr_q;
  logic [32:0]     shifted;
  logic [33:0]     diff;
  logic            fits;

  assign shifted = {rem_q, quo_q[31]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
  assign fits    = !diff[33];

  // The upper half of the dividend is already below the divisor, so only
  // the lower 32 bits need to be shifted through.
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      cnt_d = CntW'(Steps);
      rem_d = dividend_i[63:32];
      quo_d = dividend_i[31:0];
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CntW'(1);
      rem_d  = fits ? diff[31:0] : shifted[31:0];
      quo_d  = {quo_q[30:0], fits};
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ----- sv/eil_ctrl.sv -----
// ----------------------------------------------------------------------------
// eil_ctrl
// Sequencer for the lookup: clamp checks, binary search probes, segment
// reads, multiply, divide and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eil_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        cmd_i,
  output logic              in_stall_o,
  input  eil_pkg::eil_sts_t sts_i,
  output eil_pkg::eil_ctl_t ctl_o
);

  import eil_pkg::*;

  eil_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (cmd_i == CMD_QUERY)) begin
          state_d = ST_CHK_LO;
        end
      end
      ST_CHK_LO:    state_d = sts_i.x_le_c ? ST_DONE : ST_CHK_HI;
      ST_CHK_HI:    state_d = sts_i.x_ge_c ? ST_DONE : ST_PROBE_RD;
      ST_PROBE_RD:  state_d = sts_i.cnt_zero ? ST_RD_RIGHT : ST_PROBE_CMP;
      ST_PROBE_CMP: state_d = ST_PROBE_RD;
      ST_RD_RIGHT:  state_d = ST_LATCH_R;
      ST_LATCH_R:   state_d = ST_PREP;
      ST_PREP:      state_d = sts_i.den_le0 ? ST_DONE : ST_MUL;
      ST_MUL:       state_d = ST_DIV_START;
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o        = '0;
    ctl_o.rd_sel = RA_ZERO;
    ctl_o.res_sel = RS_READ;
    ctl_o.res_region = REGION_INTERP;
    in_stall_o   = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.wr_center = (cmd_i == CMD_WR_CENTER);
          ctl_o.wr_value  = (cmd_i == CMD_WR_VALUE);
          ctl_o.x_load    = (cmd_i == CMD_QUERY);
        end
      end
      ST_CHK_LO: begin
        ctl_o.search_init = 1'b1;
        if (sts_i.x_le_c) begin
          ctl_o.res_load   = 1'b1;
          ctl_o.res_region = REGION_BELOW;
        end else begin
          ctl_o.rd_sel = RA_LAST;
        end
      end
      ST_CHK_HI: begin
        if (sts_i.x_ge_c) begin
          ctl_o.res_load   = 1'b1;
          ctl_o.res_region = REGION_ABOVE;
        end
      end
      ST_PROBE_RD: begin
        if (sts_i.cnt_zero) begin
          ctl_o.rd_sel = RA_LEFT;
        end else begin
          ctl_o.rd_sel      = RA_MID;
          ctl_o.probe_issue = 1'b1;
        end
      end
      ST_PROBE_CMP: ctl_o.probe_update = 1'b1;
      ST_RD_RIGHT: begin
        ctl_o.left_latch = 1'b1;
        ctl_o.rd_sel     = RA_RIGHT;
      end
      ST_LATCH_R: ctl_o.right_latch = 1'b1;
      ST_PREP: begin
        ctl_o.prep = 1'b1;
        if (sts_i.den_le0) begin
          ctl_o.res_load = 1'b1;
          ctl_o.res_sel  = RS_LEFT;
        end
      end
      ST_MUL:       ctl_o.mul_load  = 1'b1;
      ST_DIV_START: ctl_o.div_start = 1'b1;
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          ctl_o.res_load = 1'b1;
          ctl_o.res_sel  = RS_INTERP;
        end
      end
      ST_DONE: ctl_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// ----- sv/eil_dpath.sv -----
// ----------------------------------------------------------------------------
// eil_dpath
// Center and value memories, search registers, segment arithmetic, the
// divider and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eil_dpath #(
  parameter int unsigned MAX_BINS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_en_i,
  input  logic [8:0]         cfg_wr_data_i,
  input  logic [7:0]         bin_index_i,
  input  logic signed [31:0] operand_value_i,
  input  eil_pkg::eil_ctl_t  ctl_i,
  output eil_pkg::eil_sts_t  sts_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic signed [31:0] eta_result_o,
  output logic [1:0]         region_o
);

  import eil_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BINS);
  localparam int unsigned NW = $clog2(MAX_BINS + 1);

  logic [8:0]         bin_count_q;
  logic [31:0]        bc_wide, n_wide;
  logic [NW-1:0]      n, n_m1;

  logic signed [31:0] center_mem [MAX_BINS];
  logic signed [31:0] value_mem  [MAX_BINS];
  logic signed [31:0] rc_q, rv_q;
  logic [AW-1:0]      raddr, waddr;
  logic [31:0]        widx;
  logic               idx_ok;

  logic signed [31:0] x_q;
  logic [NW-1:0]      lo_q, cnt_q, mid_q;
  logic [NW-1:0]      half, mid_d, i_sel, left_idx;

  logic signed [31:0] c0_q, v0_q;
  logic signed [32:0] dx_raw_q, den_q, dv_q;
  logic [32:0]        dv_abs;
  logic [31:0]        dx_d, dx_q, mag_q;
  logic               neg_q;
  logic [63:0]        prod_w, prod_q;
  logic [31:0]        quo;
  logic               div_done;

  logic [31:0]        res_d, res_q;
  logic [1:0]         res_region_q;
  logic               out_valid_q;
  logic [31:0]        out_eta_q;
  logic [1:0]         out_region_q;

  // A bin count below two acts as two, above the table depth as the depth.
  always_comb begin
    bc_wide = 32'(bin_count_q);
    if (bc_wide < 32'd2) begin
      n_wide = 32'd2;
    end else if (bc_wide > 32'(MAX_BINS)) begin
      n_wide = 32'(MAX_BINS);
    end else begin
      n_wide = bc_wide;
    end
  end
  assign n    = n_wide[NW-1:0];
  assign n_m1 = n - NW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q <= 9'd2;
    end else if (cfg_wr_en_i) begin
      bin_count_q <= cfg_wr_data_i;
    end
  end

  // Table memories.
  assign widx   = 32'(bin_index_i);
  assign idx_ok = (widx < 32'(MAX_BINS));
  assign waddr  = widx[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_center && idx_ok) begin
      center_mem[waddr] <= operand_value_i;
    end
    rc_q <= center_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_value && idx_ok) begin
      value_mem[waddr] <= operand_value_i;
    end
    rv_q <= value_mem[raddr];
  end

  // Binary search bookkeeping.
  assign half  = cnt_q >> 1;
  assign mid_d = lo_q + half;

  // The right end of the segment is kept inside [1, n-1].
  always_comb begin
    if (lo_q == '0) begin
      i_sel = NW'(1);
    end else if (lo_q > n_m1) begin
      i_sel = n_m1;
    end else begin
      i_sel = lo_q;
    end
  end
  assign left_idx = i_sel - NW'(1);

  always_comb begin
    unique case (ctl_i.rd_sel)
      RA_ZERO:  raddr = '0;
      RA_LAST:  raddr = n_m1[AW-1:0];
      RA_MID:   raddr = mid_d[AW-1:0];
      RA_LEFT:  raddr = left_idx[AW-1:0];
      RA_RIGHT: raddr = i_sel[AW-1:0];
      default:  raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.x_load) begin
      x_q <= operand_value_i;
    end
    if (ctl_i.search_init) begin
      lo_q  <= '0;
      cnt_q <= n;
    end else if (ctl_i.probe_update) begin
      if (rc_q < x_q) begin
        lo_q  <= mid_q + NW'(1);
        cnt_q <= cnt_q - half - NW'(1);
      end else begin
        cnt_q <= half;
      end
    end
    if (ctl_i.probe_issue) begin
      mid_q <= mid_d;
    end
  end

  // Segment arithmetic, exact in 33 bits.
  assign dv_abs = dv_q[32] ? 33'(-dv_q) : dv_q;

  always_comb begin
    if (dx_raw_q[32]) begin
      dx_d = '0;
    end else if (dx_raw_q > den_q) begin
      dx_d = den_q[31:0];
    end else begin
      dx_d = dx_raw_q[31:0];
    end
  end

  assign prod_w = mag_q * dx_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.left_latch) begin
      c0_q     <= rc_q;
      v0_q     <= rv_q;
      dx_raw_q <= {x_q[31], x_q} - {rc_q[31], rc_q};
    end
    if (ctl_i.right_latch) begin
      den_q <= {rc_q[31], rc_q} - {c0_q[31], c0_q};
      dv_q  <= {rv_q[31], rv_q} - {v0_q[31], v0_q};
    end
    if (ctl_i.prep) begin
      dx_q  <= dx_d;
      mag_q <= dv_abs[31:0];
      neg_q <= dv_q[32];
    end
    if (ctl_i.mul_load) begin
      prod_q <= prod_w;
    end
  end

  eil_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (den_q[31:0]),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  // The quotient never exceeds |v1 - v0|, so the sum stays between v0 and v1.
  always_comb begin
    unique case (ctl_i.res_sel)
      RS_READ:   res_d = rv_q;
      RS_LEFT:   res_d = v0_q;
      RS_INTERP: res_d = neg_q ? (v0_q - quo) : (v0_q + quo);
      default:   res_d = v0_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_load) begin
      res_q        <= res_d;
      res_region_q <= ctl_i.res_region;
    end
    if (ctl_i.out_load) begin
      out_eta_q    <= res_q;
      out_region_q <= res_region_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.x_le_c   = (x_q <= rc_q);
  assign sts_o.x_ge_c   = (x_q >= rc_q);
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.den_le0  = den_q[32] || (den_q == '0);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign eta_result_o = out_eta_q;
  assign region_o     = out_region_q;

endmodule

// ----- dv/eta_interpolation_lookup_core_test.sv -----
// ----------------------------------------------------------------------------
// eta_interpolation_lookup_core_test
// Self-checking testbench for the eta interpolation lookup core. It loads
// ascending, tightly spaced and jumbled center tables, runs queries below,
// above and inside the table under several bin counts, and checks every
// result beat against a behavioral lookup kept in a small scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eta_interpolation_lookup_core_test;
  import eil_pkg::*;

  localparam int BIN_LIMIT = 256;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [31:0] ETA_MIN = 32'sh80000000;
  localparam logic signed [31:0] ETA_MAX = 32'sh7FFFFFFF;
  localparam longint Q_MIN = 64'shFFFFFFFF80000000;
  localparam longint Q_MAX = 64'sh000000007FFFFFFF;

  typedef enum int {
    TBL_WIDE,
    TBL_NARROW,
    TBL_JUMBLED
  } table_shape_e;

  typedef struct packed {
    logic signed [31:0] eta;
    logic [1:0]         region;
  } eta_answer_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_wr_en_i;
  logic [8:0]         cfg_wr_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         cmd_i;
  logic [7:0]         bin_index_i;
  logic signed [31:0] operand_value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] eta_result_o;
  logic [1:0]         region_o;

  class eta_lookup_board;
    logic signed [31:0] centers [BIN_LIMIT];
    logic signed [31:0] values [BIN_LIMIT];
    logic [8:0]         bin_reg = 9'd2;
    eta_answer_t        pending_answers [$];
    int                 mismatches;
    int                 n_below;
    int                 n_above;
    int                 n_interp;
    int                 n_writes;
    int                 n_ignored;

    function int active_bins();
      int n;
      n = int'(bin_reg);
      if (n < 2) n = 2;
      if (n > BIN_LIMIT) n = BIN_LIMIT;
      return n;
    endfunction

    function eta_answer_t lookup_eta(logic signed [31:0] pos);
      eta_answer_t       ans;
      int                n;
      int                lo;
      int                cnt;
      int                half;
      int                mid;
      int                seg;
      longint            x;
      longint            c0;
      longint            c1;
      longint            v0;
      longint            v1;
      longint            den;
      longint            dx;
      longint            dv;
      longint            res;
      longint unsigned   mag;
      longint unsigned   quo;
      n = active_bins();
      x = longint'(pos);
      if (x <= longint'(centers[0])) begin
        ans.eta = values[0];
        ans.region = REGION_BELOW;
      end else if (x >= longint'(centers[n - 1])) begin
        ans.eta = values[n - 1];
        ans.region = REGION_ABOVE;
      end else begin
        // Lower-bound search for the first center not below the position.
        lo = 0;
        cnt = n;
        while (cnt > 0) begin
          half = cnt / 2;
          mid = lo + half;
          if (longint'(centers[mid]) < x) begin
            lo = mid + 1;
            cnt = cnt - half - 1;
          end else begin
            cnt = half;
          end
        end
        seg = (lo < 1) ? 1 : ((lo > n - 1) ? n - 1 : lo);
        c0 = longint'(centers[seg - 1]);
        c1 = longint'(centers[seg]);
        v0 = longint'(values[seg - 1]);
        v1 = longint'(values[seg]);
        den = c1 - c0;
        dx = x - c0;
        dv = v1 - v0;
        if (den <= 0) begin
          res = v0;
        end else begin
          if (dx < 0) dx = 0;
          if (dx > den) dx = den;
          mag = (dv < 0) ? longint'(-dv) : longint'(dv);
          // Both factors stay below 2**32, so the product fits in 64 bits.
          quo = (mag * longint'(dx)) / longint'(den);
          res = (dv < 0) ? v0 - longint'(quo) : v0 + longint'(quo);
        end
        ans.eta = res[31:0];
        ans.region = REGION_INTERP;
      end
      return ans;
    endfunction

    function void note_beat(logic [1:0] cmd, logic [7:0] idx, logic signed [31:0] opv);
      eta_answer_t ans;
      case (cmd)
        CMD_WR_CENTER: begin
          centers[idx] = opv;
          n_writes++;
        end
        CMD_WR_VALUE: begin
          values[idx] = opv;
          n_writes++;
        end
        CMD_QUERY: begin
          ans = lookup_eta(opv);
          pending_answers.push_back(ans);
          case (ans.region)
            REGION_BELOW: n_below++;
            REGION_ABOVE: n_above++;
            default: n_interp++;
          endcase
        end
        default: n_ignored++;
      endcase
    endfunction

    function void flag_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("ERROR: %s", what);
    endfunction

    function void check_beat(logic signed [31:0] eta, logic [1:0] region);
      eta_answer_t want;
      if (pending_answers.size() == 0) begin
        flag_mismatch($sformatf("result with no query pending: eta %0d region %0d",
                                eta, region));
        return;
      end
      want = pending_answers.pop_front();
      if (eta !== want.eta || region !== want.region) begin
        flag_mismatch($sformatf("expected eta %0d region %0d, got eta %0d region %0d",
                                want.eta, want.region, eta, region));
      end
    endfunction
  endclass

  eta_lookup_board board = new;

  longint plan_center [BIN_LIMIT];
  int     plan_bins = 2;
  bit     tx_calm;
  bit     rx_calm;
  int     hold_cycles;
  int     rx_run;
  int     rx_pick;
  int     cycle_count;
  int     bin_settings;

  eta_interpolation_lookup_core #(
    .MAX_BINS(BIN_LIMIT)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .bin_index_i     (bin_index_i),
    .operand_value_i (operand_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .eta_result_o    (eta_result_o),
    .region_o        (region_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      board.note_beat(cmd_i, bin_index_i, operand_value_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_beat(eta_result_o, region_o);
    end
  end

  // Result side: random stall runs, plus a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else if (rx_run > 0) begin
      rx_run--;
    end else begin
      out_stall_i <= !rx_calm && ($urandom_range(0, 99) < 40);
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 80) rx_run = $urandom_range(0, 3);
      else if (rx_pick < 97) rx_run = $urandom_range(4, 15);
      else rx_run = $urandom_range(20, 60);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("eta_interpolation_lookup_core: mismatch");
      $finish;
    end
  end

  task automatic tx_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 55) n = 0;
    else if (r < 88) n = $urandom_range(1, 3);
    else if (r < 98) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 80);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      cmd_i <= 2'($urandom_range(0, 3));
      bin_index_i <= 8'($urandom_range(0, 255));
      operand_value_i <= $urandom;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic put_beat(logic [1:0] cmd, logic [7:0] idx, logic signed [31:0] opv);
    tx_gap();
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    bin_index_i <= idx;
    operand_value_i <= opv;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_bins(logic [8:0] count);
    wait_drained();
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= count;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    board.bin_reg = count;
    plan_bins = board.active_bins();
    bin_settings++;
  endtask

  function automatic longint pick_between(longint lo, longint hi);
    longint unsigned span;
    if (hi <= lo) return lo;
    span = longint'(hi - lo + 1);
    return lo + longint'({$urandom, $urandom} % span);
  endfunction

  function automatic logic signed [31:0] pick_position();
    int     r;
    int     k;
    longint p;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      p = plan_center[0] - longint'($urandom_range(0, 1000));
    end else if (r < 12) begin
      p = plan_center[plan_bins - 1] + longint'($urandom_range(0, 1000));
    end else if (r < 20) begin
      p = plan_center[$urandom_range(0, plan_bins - 1)];
    end else if (r < 28) begin
      p = longint'($signed($urandom));
    end else begin
      k = $urandom_range(1, plan_bins - 1);
      p = pick_between(plan_center[k - 1], plan_center[k]);
    end
    if (p < Q_MIN) p = Q_MIN;
    if (p > Q_MAX) p = Q_MAX;
    return p[31:0];
  endfunction

  // Writes the first count entries of both tables; the rest keep what they hold.
  task automatic load_table(table_shape_e shape, int count);
    longint             c;
    logic signed [31:0] v;
    case (shape)
      TBL_WIDE: c = Q_MIN;
      TBL_NARROW: c = longint'($urandom_range(0, 2097152)) - 64'sd1048576;
      default: c = 0;
    endcase
    for (int i = 0; i < count; i++) begin
      if (shape == TBL_JUMBLED) c = longint'($signed($urandom));
      else if (shape == TBL_WIDE && i == count - 1) c = Q_MAX;
      plan_center[i] = c;
      put_beat(CMD_WR_CENTER, 8'(i), c[31:0]);
      case ($urandom_range(0, 3))
        0: v = ETA_MIN;
        1: v = ETA_MAX;
        default: v = $urandom;
      endcase
      put_beat(CMD_WR_VALUE, 8'(i), v);
      if (shape == TBL_WIDE) c += longint'($urandom_range(1, 16777215));
      else if (shape == TBL_NARROW) c += longint'($urandom_range(0, 4096));
    end
  endtask

  task automatic random_burst(int count);
    int     r;
    int     idx;
    longint lo;
    longint hi;
    longint c;
    tx_calm = ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      idx = $urandom_range(0, BIN_LIMIT - 1);
      if (r < 62) begin
        put_beat(CMD_QUERY, 8'(idx), pick_position());
      end else if (r < 76) begin
        put_beat(CMD_WR_VALUE, 8'(idx), $urandom);
      end else if (r < 90) begin
        // Keep the centers in order by staying between the neighbors.
        lo = (idx > 0) ? plan_center[idx - 1] : Q_MIN;
        hi = (idx < BIN_LIMIT - 1) ? plan_center[idx + 1] : Q_MAX;
        c = pick_between(lo, hi);
        plan_center[idx] = c;
        put_beat(CMD_WR_CENTER, 8'(idx), c[31:0]);
      end else if (r < 95) begin
        put_beat(CMD_UNUSED, 8'(idx), $urandom);
      end else begin
        put_beat(CMD_QUERY, 8'(idx), $urandom);
      end
      if ($urandom_range(0, 149) == 0) wait_drained();
    end
  endtask

  initial begin
    logic [8:0] phase_bins [10];
    longint     c0;
    longint     c1;
    longint     p;
    rst_ni = 1'b0;
    cfg_wr_en_i = 1'b0;
    cfg_wr_data_i = '0;
    in_valid_i = 1'b0;
    cmd_i = CMD_WR_CENTER;
    bin_index_i = '0;
    operand_value_i = '0;
    out_stall_i = 1'b0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    hold_cycles = 0;
    rx_run = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed checks, first with the two bins that reset leaves in use.
    // The first load covers every entry, so no later query reads an unwritten one.
    load_table(TBL_WIDE, BIN_LIMIT);
    c0 = plan_center[0];
    c1 = plan_center[1];
    put_beat(CMD_QUERY, 8'h00, ETA_MIN);
    put_beat(CMD_QUERY, 8'hFF, c1[31:0]);
    put_beat(CMD_QUERY, 8'h5A, ETA_MAX);
    p = c0 + (c1 - c0) / 2;
    put_beat(CMD_QUERY, 8'hA5, p[31:0]);
    p = c0 + 1;
    put_beat(CMD_QUERY, 8'h00, p[31:0]);
    p = c1 - 1;
    put_beat(CMD_QUERY, 8'h00, p[31:0]);
    put_beat(CMD_UNUSED, 8'hFF, 32'hFFFFFFFF);

    set_bins(9'd256);
    put_beat(CMD_QUERY, 8'h00, ETA_MAX);
    put_beat(CMD_QUERY, 8'h00, plan_center[100][31:0]);
    p = plan_center[254] + 1;
    put_beat(CMD_QUERY, 8'h00, p[31:0]);
    put_beat(CMD_QUERY, 8'h00, ETA_MAX - 1);
    put_beat(CMD_QUERY, 8'h00, 32'sd0);
    // Largest swing between two neighbors, falling.
    put_beat(CMD_WR_VALUE, 8'd0, ETA_MAX);
    put_beat(CMD_WR_VALUE, 8'd1, ETA_MIN);
    p = c1 - 2;
    put_beat(CMD_QUERY, 8'h00, p[31:0]);

    phase_bins = '{9'd256, 9'd0, 9'd511, 9'd12, 9'd1, 9'd10, 9'd257, 9'd3, 9'd0, 9'd128};
    phase_bins[8] = 9'($urandom_range(4, 16));
    for (int ph = 0; ph < 10; ph++) begin
      set_bins(phase_bins[ph]);
      case (ph)
        3: load_table(TBL_JUMBLED, plan_bins);
        5: load_table(TBL_NARROW, plan_bins);
        8: load_table(TBL_WIDE, plan_bins);
        default: ;
      endcase
      if (ph == 4) begin
        // Hold the result side off while queries keep coming, so the core
        // backs up and stalls its input.
        hold_cycles = 400;
        tx_calm = 1'b1;
        for (int i = 0; i < 24; i++) begin
          put_beat(CMD_QUERY, 8'($urandom_range(0, 255)), pick_position());
        end
      end
      random_burst(10);
    end

    wait_drained();
    $display("Covered %0d queries: %0d clamped below, %0d clamped above, %0d interpolated,",
             board.n_below + board.n_above + board.n_interp, board.n_below, board.n_above,
             board.n_interp);
    $display("with %0d table writes, %0d unused-command beats and %0d bin-count settings.",
             board.n_writes, board.n_ignored, bin_settings);
    if (board.mismatches == 0 && board.pending_answers.size() == 0) begin
      $display("eta_interpolation_lookup_core: match");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("eta_interpolation_lookup_core: mismatch");
    end
    $finish;
  end

endmodule
